### rtl/core/u16u8_pkg.sv
// shared types and constants of the utf-16 to utf-8 transcoder
package u16u8_pkg;

  localparam int unsigned UnitW = 16;
  localparam int unsigned CpW   = 21;
  localparam int unsigned OffW  = 10;

  localparam logic [CpW-1:0]   SuppBase   = 21'h010000;
  localparam logic [CpW-1:0]   LowBase    = 21'h00DC00;
  localparam logic [5:0]       HighPrefix = 6'b110110;
  localparam logic [CpW-1:0]   Max1Byte   = 21'h00007F;
  localparam logic [CpW-1:0]   Max2Byte   = 21'h0007FF;
  localparam logic [CpW-1:0]   Max3Byte   = 21'h00FFFF;
  localparam logic [7:0]       Lead2      = 8'hC0;
  localparam logic [7:0]       Lead3      = 8'hE0;
  localparam logic [7:0]       Lead4      = 8'hF0;
  localparam logic [7:0]       ContMark   = 8'h80;

  // byte count minus one
  localparam logic [1:0] Len1 = 2'd0;
  localparam logic [1:0] Len2 = 2'd1;
  localparam logic [1:0] Len3 = 2'd2;
  localparam logic [1:0] Len4 = 2'd3;

  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] utf8_byte;
    logic       last_of_char;
    logic       string_done;
  } out_item_t;

  // one encoded character, first byte in the top lane
  typedef struct packed {
    logic [31:0] bytes;
    logic [1:0]  len_m1;
    logic        done;
  } char_t;

  typedef struct packed {
    logic  push;
    char_t entry;
  } q_wr_t;

  typedef struct packed {
    logic  empty;
    logic  full;
    char_t head;
  } q_stat_t;

endpackage

### rtl/core/u16u8_front.sv
// front part: accepts code units, pairs surrogates and encodes the character
module u16u8_front
  import u16u8_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_i,
  input  logic     q_full_i,
  output q_wr_t    q_wr_o
);

  logic            pend_q, pend_d;
  logic [OffW-1:0] hi_q, hi_d;
  logic            accept, hold;
  logic [CpW-1:0]  cp;
  char_t           enc;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign hold       = !pend_q && (in_i.code_unit[15:10] == HighPrefix) && !in_i.end_of_string;

  always_comb begin
    if (pend_q) begin
      cp = SuppBase + {1'b0, hi_q, {OffW{1'b0}}} + {{(CpW-UnitW){1'b0}}, in_i.code_unit}
           - LowBase;
    end else begin
      cp = {{(CpW-UnitW){1'b0}}, in_i.code_unit};
    end
  end

  always_comb begin
    enc.done = in_i.end_of_string;
    priority if (cp <= Max1Byte) begin
      enc.len_m1 = Len1;
      enc.bytes  = {cp[7:0], 24'd0};
    end else if (cp <= Max2Byte) begin
      enc.len_m1 = Len2;
      enc.bytes  = {Lead2 | {3'd0, cp[10:6]}, ContMark | {2'd0, cp[5:0]}, 16'd0};
    end else if (cp <= Max3Byte) begin
      enc.len_m1 = Len3;
      enc.bytes  = {Lead3 | {4'd0, cp[15:12]}, ContMark | {2'd0, cp[11:6]},
                    ContMark | {2'd0, cp[5:0]}, 8'd0};
    end else begin
      enc.len_m1 = Len4;
      enc.bytes  = {Lead4 | {5'd0, cp[20:18]}, ContMark | {2'd0, cp[17:12]},
                    ContMark | {2'd0, cp[11:6]}, ContMark | {2'd0, cp[5:0]}};
    end
  end

  assign q_wr_o.push  = accept && !hold;
  assign q_wr_o.entry = enc;

  always_comb begin
    pend_d = pend_q;
    hi_d   = hi_q;
    if (accept) begin
      if (pend_q) begin
        pend_d = 1'b0;
        hi_d   = '0;
      end else if (hold) begin
        pend_d = 1'b1;
        hi_d   = in_i.code_unit[OffW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      hi_q   <= '0;
    end else begin
      pend_q <= pend_d;
      hi_q   <= hi_d;
    end
  end

endmodule

### rtl/core/u16u8_fifo.sv
// short queue of encoded characters between front and back
module u16u8_fifo
  import u16u8_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  q_wr_t   q_wr_i,
  input  logic    pop_i,
  output q_stat_t q_stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  char_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign do_push = q_wr_i.push && (cnt_q != FullCnt);
  assign do_pop  = pop_i && (cnt_q != '0);

  assign q_stat_o.empty = (cnt_q == '0);
  assign q_stat_o.full  = (cnt_q == FullCnt);
  assign q_stat_o.head  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= q_wr_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### rtl/core/u16u8_back.sv
// back part: sends the bytes of one character, one per transfer, through the output register
module u16u8_back
  import u16u8_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  q_stat_t   q_stat_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_o
);

  logic        cur_vld_q;
  logic [31:0] cur_bytes_q;
  logic [1:0]  cur_left_q;
  logic        cur_done_q;
  logic        out_vld_q;
  out_item_t   out_q;
  logic        emit, cur_last;

  assign cur_last = (cur_left_q == Len1);
  assign emit     = cur_vld_q && (!out_vld_q || !out_stall_i);
  assign pop_o    = !q_stat_i.empty && (!cur_vld_q || (emit && cur_last));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (pop_o) begin
        cur_vld_q <= 1'b1;
      end else if (emit && cur_last) begin
        cur_vld_q <= 1'b0;
      end
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_bytes_q <= q_stat_i.head.bytes;
      cur_left_q  <= q_stat_i.head.len_m1;
      cur_done_q  <= q_stat_i.head.done;
    end else if (emit) begin
      cur_bytes_q <= {cur_bytes_q[23:0], 8'd0};
      cur_left_q  <= cur_left_q - 1'b1;
    end
    if (emit) begin
      out_q.utf8_byte    <= cur_bytes_q[31:24];
      out_q.last_of_char <= cur_last;
      out_q.string_done  <= cur_last && cur_done_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

endmodule

### rtl/core/utf16_to_utf8_transcoder_core.sv
// top level of the utf-16 to utf-8 transcoder
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+--------------------------------------
//   in      | in  | in_valid_i/in_stall_o  | in_i: code_unit, end_of_string
//   out     | out | out_valid_o/out_stall_i| out_o: utf8_byte, last_of_char,
//           |     |                        |        string_done
//
// the output register sends one byte per cycle while the output is not stalled; a
// character of n bytes leaves the back part as n byte transfers
// a held high surrogate produces no byte
// the front accepts a unit every cycle while the character queue has room
// first byte passes through the queue, current-character and output registers
// reset clears the surrogate state, the queue and both valid flags
module utf16_to_utf8_transcoder_core
  import u16u8_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_o
);

  // front to queue: push strobe and encoded character
  q_wr_t   q_wr;
  // queue to back: head entry and fill status
  q_stat_t q_stat;
  logic    q_pop;

  // pairs surrogates, encodes, and stalls the input while the queue is full
  u16u8_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .q_full_i   (q_stat.full),
    .q_wr_o     (q_wr)
  );

  // decouples the front from output stalls
  u16u8_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_wr_i   (q_wr),
    .pop_i    (q_pop),
    .q_stat_o (q_stat)
  );

  // serializes each character into byte transfers
  u16u8_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

`ifndef SYNTHESIS
  // the front never pushes into a full queue
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_wr.push |-> !q_stat.full)
    else $error("push into full character queue");

  // the back never pops an empty queue
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty character queue");

  // end of string only ever closes a character
  a_done_on_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_o.string_done || out_o.last_of_char))
    else $error("string_done on a byte that does not end a character");
`endif

endmodule
